[rtl/core/dcmf_pkg.sv]
package dcmf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_RADIUS_DEF = 16;
  localparam int MAX_HEIGHT     = 4096;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int OCOL_W     = 11;
  localparam int WID_CFG_W  = 12;
  localparam int HGT_W      = 13;
  localparam int RAD_CFG_W  = 5;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [WID_CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [HGT_W-1:0]     HEIGHT_RST = 13'd480;
  localparam logic [RAD_CFG_W-1:0] RADIUS_RST = 5'd12;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [OCOL_W-1:0] out_col;
    logic [PIX_W-1:0]  dark_value;
    logic              last;
  } dark_t;

  function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[rtl/core/dcmf_pix_if.sv]
interface dcmf_pix_if import dcmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink (input valid, input blue, input green, input red, output ready);
endinterface

[rtl/core/dcmf_dark_if.sv]
interface dcmf_dark_if import dcmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  out_row;
  logic [OCOL_W-1:0] out_col;
  logic [PIX_W-1:0]  dark_value;
  logic              last;

  modport source (output valid, output out_row, output out_col, output dark_value,
                  output last, input ready);
  modport sink (input valid, input out_row, input out_col, input dark_value,
                input last, output ready);
endinterface

[rtl/core/dcmf_cfg_if.sv]
interface dcmf_cfg_if import dcmf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/dcmf_cfg_regs.sv]
module dcmf_cfg_regs import dcmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  dcmf_cfg_if.sink                           cfg,
  output logic [$clog2(MAX_WIDTH):0]         w_eff,
  output logic [HGT_W-1:0]                   h_eff,
  output logic [$clog2(MAX_RADIUS+1)-1:0]    rad_eff
);

  localparam int WW = $clog2(MAX_WIDTH) + 1;
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int ZW = (WW > WID_CFG_W) ? WW : WID_CFG_W;
  localparam int RZ = (RW > RAD_CFG_W) ? RW : RAD_CFG_W;

  logic [WID_CFG_W-1:0] width_reg;
  logic [HGT_W-1:0]     height_reg;
  logic [RAD_CFG_W-1:0] radius_reg;
  logic [ZW-1:0]        wz;
  logic [RZ-1:0]        rz;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
      radius_reg <= RADIUS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WIDTH:  width_reg  <= cfg.data[WID_CFG_W-1:0];
        REG_HEIGHT: height_reg <= cfg.data[HGT_W-1:0];
        REG_RADIUS: radius_reg <= cfg.data[RAD_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to what the line store and counters can hold
  always_comb begin
    wz = ZW'(width_reg);
    rz = RZ'(radius_reg);
    if (width_reg == '0) w_eff = WW'(1);
    else if (wz > ZW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(wz);

    if (height_reg == '0) h_eff = HGT_W'(1);
    else if (height_reg > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = height_reg;

    if (rz > RZ'(MAX_RADIUS)) rad_eff = RW'(MAX_RADIUS);
    else rad_eff = RW'(rz);
  end

endmodule

[rtl/core/dcmf_engine.sv]
module dcmf_engine import dcmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  dcmf_pix_if.sink                           pix,
  input  logic [$clog2(MAX_WIDTH):0]         w_eff,
  input  logic [HGT_W-1:0]                   h_eff,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]    rad_eff,
  output dark_t                              res,
  output logic                               res_valid,
  input  logic                               res_ready
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int KW      = RW + 1;
  localparam int LINES   = 2 * MAX_RADIUS;
  localparam int SW      = $clog2(LINES);
  localparam int WIN_LEN = 2 * MAX_RADIUS + 1;
  localparam int PW      = $clog2(WIN_LEN);
  localparam int LMD     = LINES * (2 ** CW);
  localparam int XW      = ((CW + 2) > 14) ? (CW + 2) : 14;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_VERT, S_WRITE, S_HORZ, S_EMIT_C, S_EMIT_B, S_DONE
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] row;
  logic [SW-1:0]    row_slot;
  logic [CW-1:0]    col;
  logic [PW-1:0]    wptr;
  logic [PIX_W-1:0] pmin;
  logic [PIX_W-1:0] vmin;
  logic [PIX_W-1:0] hmin;
  logic             cen;
  logic             bord;
  logic [KW-1:0]    k;
  logic [SW-1:0]    rslot;
  logic [PW-1:0]    rptr;
  logic             rd_pend;

  logic [PIX_W-1:0] line_mem [LMD];
  logic [PIX_W-1:0] win_mem [WIN_LEN];
  logic [PIX_W-1:0] lm_q;
  logic [PIX_W-1:0] wm_q;

  logic [KW-1:0]    two_rad;
  logic [XW-1:0]    row_x, col_x, rad_x, tr_x, h_x, w_x;
  logic             do_vert, centre_hit, inner;
  logic             issue, lm_re, wm_re, mem_we;
  logic             col_wrap, row_wrap;
  logic [PIX_W-1:0] pix_min;

  always_comb begin
    two_rad    = {rad_eff, 1'b0};
    row_x      = XW'(row);
    col_x      = XW'(col);
    rad_x      = XW'(rad_eff);
    tr_x       = XW'(two_rad);
    h_x        = XW'(h_eff);
    w_x        = XW'(w_eff);
    do_vert    = (row_x >= tr_x) && (rad_eff != '0);
    centre_hit = (row_x >= tr_x) && (col_x >= tr_x) && (row_x < h_x) && (col_x < w_x);
    inner      = (row_x >= rad_x) && (row_x + rad_x < h_x) &&
                 (col_x >= rad_x) && (col_x + rad_x < w_x);
    issue      = ((state == S_VERT) || (state == S_HORZ)) && (k != two_rad);
    lm_re      = issue && (state == S_VERT);
    wm_re      = issue && (state == S_HORZ);
    mem_we     = (state == S_WRITE);
    col_wrap   = (col_x + XW'(1)) >= w_x;
    row_wrap   = (row_x + XW'(1)) >= h_x;
    pix_min    = min8(min8(pix.blue, pix.green), pix.red);
  end

  assign pix.ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT_C) || (state == S_EMIT_B);

  always_comb begin
    if (state == S_EMIT_C) begin
      res.out_row    = row - ROW_W'(rad_eff);
      res.out_col    = OCOL_W'(col - CW'(rad_eff));
      res.dark_value = hmin;
      res.last       = !bord;
    end else begin
      res.out_row    = row;
      res.out_col    = OCOL_W'(col);
      res.dark_value = pmin;
      res.last       = 1'b1;
    end
  end

  // One item is in flight at a time, so a read never meets a pending write
  // to the same entry: every write lands in S_WRITE, before the next read.
  always_ff @(posedge clk) begin
    if (mem_we) line_mem[{row_slot, col}] <= pmin;
    if (lm_re) lm_q <= line_mem[{rslot, col}];
  end

  always_ff @(posedge clk) begin
    if (mem_we) win_mem[wptr] <= vmin;
    if (wm_re) wm_q <= win_mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      row      <= '0;
      row_slot <= '0;
      col      <= '0;
      wptr     <= '0;
      k        <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        S_IDLE: begin
          if (pix.valid) begin
            pmin  <= pix_min;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          vmin  <= pmin;
          cen   <= centre_hit;
          bord  <= !inner;
          k     <= '0;
          rslot <= (row_slot == '0) ? SW'(LINES - 1) : row_slot - 1'b1;
          state <= do_vert ? S_VERT : S_WRITE;
        end
        S_VERT: begin
          // walk back over the stored lines of this column
          if (issue) begin
            rslot <= (rslot == '0) ? SW'(LINES - 1) : rslot - 1'b1;
            k     <= k + 1'b1;
          end
          if (rd_pend) vmin <= min8(vmin, lm_q);
          if (!issue && !rd_pend) state <= S_WRITE;
        end
        S_WRITE: begin
          wptr  <= (wptr == PW'(WIN_LEN - 1)) ? '0 : wptr + 1'b1;
          rptr  <= (wptr == '0) ? PW'(WIN_LEN - 1) : wptr - 1'b1;
          hmin  <= vmin;
          k     <= '0;
          if (cen && (rad_eff != '0)) state <= S_HORZ;
          else if (cen) state <= S_EMIT_C;
          else if (bord) state <= S_EMIT_B;
          else state <= S_DONE;
        end
        S_HORZ: begin
          if (issue) begin
            rptr <= (rptr == '0) ? PW'(WIN_LEN - 1) : rptr - 1'b1;
            k    <= k + 1'b1;
          end
          if (rd_pend) hmin <= min8(hmin, wm_q);
          if (!issue && !rd_pend) state <= S_EMIT_C;
        end
        S_EMIT_C: begin
          if (res_ready) state <= bord ? S_EMIT_B : S_DONE;
        end
        S_EMIT_B: begin
          if (res_ready) state <= S_DONE;
        end
        S_DONE: begin
          // advance the raster position
          if (col_wrap) begin
            col <= '0;
            if (row_wrap) begin
              row      <= '0;
              row_slot <= '0;
            end else begin
              row      <= row + 1'b1;
              row_slot <= (row_slot == SW'(LINES - 1)) ? '0 : row_slot + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_VERT || state == S_HORZ))
    else $error("read in flight outside a memory walk");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !rd_pend)
    else $error("store written while a read is pending");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_VERT || state == S_HORZ) |-> (k <= two_rad))
    else $error("walk ran past the window");

  a_accept_to_setup: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> (state == S_SETUP))
    else $error("accepted request did not start processing");

  a_centre_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_C) |-> cen)
    else $error("centre emitted without a completed window");
`endif

endmodule

[rtl/core/dcmf_out_reg.sv]
module dcmf_out_reg import dcmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dark_t       res,
  input  logic        res_valid,
  output logic        res_ready,
  dcmf_dark_if.source dark
);

  logic  held;
  dark_t data;

  assign res_ready       = !held || dark.ready;
  assign dark.valid      = held;
  assign dark.out_row    = data.out_row;
  assign dark.out_col    = data.out_col;
  assign dark.dark_value = data.dark_value;
  assign dark.last       = data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (res_ready) begin
      held <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) data <= res;
  end

endmodule

[rtl/core/dark_channel_min_filter.sv]
// Dark channel minimum filter over a raster-order BGR pixel stream.
// pix: one request per pixel (blue, green, red), frame in raster order.
// dark: results carrying row, column and dark value; last marks the final
//   result caused by a pixel. A pixel gives zero, one or two results: a
//   completed window centre (r rows up, r columns left) first, then the
//   pixel's own value if it lies within r of an edge.
// cfg: register writes (0 width, 1 height, 2 radius); write only while idle.
// Each pixel passes through the idle, setup, write and done states, plus a
// vertical walk over the line store (rows at or beyond 2r, r > 0), plus a
// horizontal walk over the column window (completed centres, r > 0), plus
// one offer state per result. Each walk reads one entry per cycle and
// folds in the last read before it ends. The next pixel is taken only
// when one is done.
// A result moves into the output register in the cycle it is offered when
// that register is empty or being emptied; while the receiver stalls with
// the register full, the block holds at the next result it must offer and
// takes no new pixel.
// Reset clears the raster position and the registers to 640 x 480, r = 12.
// The line store and column window need no clearing.
module dark_channel_min_filter import dcmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dcmf_cfg_if.sink    cfg,
  dcmf_pix_if.sink    pix,
  dcmf_dark_if.source dark
);

  logic [$clog2(MAX_WIDTH):0]      w_eff;
  logic [HGT_W-1:0]                h_eff;
  logic [$clog2(MAX_RADIUS+1)-1:0] rad_eff;
  dark_t                           res;
  logic                            res_valid;
  logic                            res_ready;

  dcmf_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .rad_eff (rad_eff)
  );

  dcmf_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .rad_eff   (rad_eff),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  dcmf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .dark      (dark)
  );

endmodule
